// ===== rtl/tpot_pkg.sv =====
// shared types and widths for the thermopile object temperature pipeline
package tpot_pkg;

	// divisor magnitude and partial remainder width
	localparam int UD_W = 43;
	// quotient bits produced by the divider, one per stage
	localparam int Q_W = 43;
	// die temperature to the fourth power, kelvin^4
	localparam int T4_W = 38;
	// square root stages and operand width
	localparam int SQ_STEPS = 32;
	localparam int SQ_W = 64;

	// side information that rides along with the divider
	typedef struct packed {
		logic [T4_W-1:0] t4;
		logic            neg;
		logic            dz;
		logic            cap;
	} div_side_t;

endpackage

// ===== rtl/thermopile_object_temperature.sv =====
// top level: thermopile object temperature conversion pipeline
//
// Input beats arrive on s_tvalid/s_tready/s_tdata: raw_volt in bits 15:0 and
// raw_temp in bits 31:16, both two's complement. Each beat gives one result
// beat on m_tvalid/m_tready/m_tdata, object_temp (signed, whole degrees C) in
// bits 10:0, with m_tuser carrying result_valid. result_valid is low when the
// sensitivity is zero, the root argument is negative (object_temp 0) or the
// result clipped at either end of the range (object_temp 1023 or -512).
// cfg_we/cfg_wdata load the 12-bit sensitivity S0; write it only while idle.
// Throughput is one beat per cycle while m_tready is high. The pipeline is
// 14 polynomial stages, the 43-stage divider, the two 32-stage square roots
// and the rounding stages.
// Every stage has its own valid bit. When m_tready is low the output stage
// holds and empty stages behind it keep filling, so s_tready only drops once
// the first stage is full and frozen; nothing is lost or repeated.
// Reset empties the pipeline and sets S0 to 640.
module thermopile_object_temperature (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // raw_volt [15:0], raw_temp [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // object_temp [10:0], zero [15:11]
	output logic        m_tuser    // result_valid [0]
);
	import tpot_pkg::*;

	localparam int NS = 126;

	localparam logic signed [63:0] VOS_C0 = -(64'sd29400000 * 64'sd4294967296);
	localparam logic signed [63:0] P_C0   = 64'sd1000000000 * 64'sd4294967296;
	// reciprocal of 125 and of 78125 for exact division by 1000 and 1e7
	localparam logic [31:0] RECIP_125   = 32'd2199023256;
	localparam logic [45:0] RECIP_78125 = 46'd59029581035871;
	// 1e13 = 5^13 * 2^13
	localparam logic [30:0] FIVE_13     = 31'd1220703125;
	localparam logic signed [32:0] KELVIN_Q20 = 33'sd286418534;

	// carried through the polynomial stages; sgn is the divisor sign and
	// becomes the quotient sign once the numerator is known
	typedef struct packed {
		logic [UD_W-1:0] ud;
		logic            sgn;
		logic            dz;
		logic [T4_W-1:0] t4;
	} car_t;

	function automatic logic signed [31:0] rnd_q32(input logic signed [63:0] n);
		logic [63:0] mag;
		logic [31:0] m;
		mag = n[63] ? 64'(-n) : 64'(n);
		m   = 32'((mag + 64'd2147483648) >> 32);
		return n[63] ? -$signed(m) : $signed(m);
	endfunction

	logic signed [15:0] raw_volt;
	logic signed [15:0] raw_temp;
	logic [11:0]        s0_q;
	logic [NS:1]        v_q;
	logic [NS:1]        vin;
	logic [NS+1:1]      adv;
	logic               en;
	logic               in_acc;
	logic               out_acc;

	assign raw_volt = s_tdata[15:0];
	assign raw_temp = s_tdata[31:16];

	// sensitivity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_q <= 12'd640;
		end else if (cfg_we) begin
			s0_q <= cfg_wdata;
		end
	end

	// stage advance: a stage loads when the pipe moves or it is empty
	always_comb begin
		en = m_tready | ~v_q[NS];
		for (int k = 1; k <= NS; k++) begin
			adv[k] = en | ~v_q[k];
		end
		adv[NS+1] = m_tready;
	end

	assign vin = {v_q[NS-1:1], s_tvalid};

	// valid bits; a stage that hands its beat on without refilling empties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (adv[k]) begin
					v_q[k] <= vin[k];
				end else if (adv[k+1]) begin
					v_q[k] <= 1'b0;
				end
			end
		end
	end

	assign s_tready = adv[1];
	assign in_acc   = s_tvalid & s_tready;
	assign out_acc  = m_tvalid & m_tready;

	// polynomial front end
	logic signed [16:0] dd_c;
	logic signed [33:0] dd2_c;
	logic [26:0]        tsum_c;
	logic [25:0]        t_c;
	logic signed [33:0] rv156_c;
	logic [34:0]        em_c;
	logic [43:0]        udm_c;
	logic signed [35:0] f_c;

	logic signed [33:0] rv156_s1, rv156_s2, rv156_s3, rv156_s4;
	logic signed [16:0] dd_s1;
	logic [30:0]        dd2_s1;
	logic [51:0]        tt_s1;
	logic signed [37:0] av_s2;
	logic [43:0]        bv_s2;
	logic signed [38:0] ap_s2;
	logic [45:0]        bp_s2;
	logic [26:0]        t2_s2;
	logic signed [63:0] vosn_s3, pn_s3;
	logic [53:0]        tq_s3;
	logic signed [31:0] vos_s4, p_s4;
	logic [T4_W-1:0]    t4_s4, t4_s5;
	logic signed [34:0] e_s5, e_s6, e_s7, e_s8, e_s9, e_s10, e_s11;
	logic signed [43:0] den_s5;
	logic [29:0]        y_s6;
	logic [22:0]        enm_s7;
	logic [45:0]        sq_s8;
	logic [44:0]        w_s9;
	logic [68:0]        pl_s10;
	logic [67:0]        ph_s10;
	logic [28:0]        q2_s11;
	car_t               car_s6, car_s7, car_s8, car_s9, car_s10, car_s11;
	car_t               car_s12, car_s13;
	logic [32:0]        num_s12;
	logic [63:0]        prod_s13;
	logic [UD_W-1:0]    rem_s14, ud_s14;
	logic [Q_W-1:0]     low_s14;
	div_side_t          side_s14;

	always_comb begin
		dd_c    = {raw_temp[15], raw_temp} - 17'sd3200;
		dd2_c   = dd_c * dd_c;
		tsum_c  = {{2{raw_temp[15]}}, raw_temp, 9'b0} + 27'd17901158;
		t_c     = tsum_c[25:0];
		rv156_c = 34'(raw_volt) * 34'sd156250;
		em_c    = e_s5[34] ? 35'(-e_s5) : 35'(e_s5);
		udm_c   = den_s5[43] ? 44'(-den_s5) : 44'(den_s5);
		f_c     = 36'(e_s11) + $signed(36'(q2_s11));
	end

	always_ff @(posedge clk) begin
		// die offset, its square, Tdie squared, scaled voltage
		if (adv[1]) begin
			rv156_s1 <= rv156_c;
			dd_s1    <= dd_c;
			dd2_s1   <= dd2_c[30:0];
			tt_s1    <= 52'(t_c) * 52'(t_c);
		end
		// polynomial coefficient products
		if (adv[2]) begin
			rv156_s2 <= rv156_s1;
			av_s2    <= 38'sd570000 * 38'(dd_s1);
			bv_s2    <= 44'd4630 * 44'(dd2_s1);
			ap_s2    <= 39'sd1750000 * 39'(dd_s1);
			bp_s2    <= 46'd16780 * 46'(dd2_s1);
			t2_s2    <= 27'((tt_s1 + 52'd8388608) >> 24);
		end
		// offset and sensitivity sums, Tdie^4 product
		if (adv[3]) begin
			rv156_s3 <= rv156_s2;
			vosn_s3  <= VOS_C0 - (64'(av_s2) <<< 25) + $signed(64'(bv_s2) << 18);
			pn_s3    <= P_C0 + (64'(ap_s2) <<< 25) - $signed(64'(bp_s2) << 18);
			tq_s3    <= 54'(t2_s2) * 54'(t2_s2);
		end
		// round sums to picovolts and parts per 1e9
		if (adv[4]) begin
			rv156_s4 <= rv156_s3;
			vos_s4   <= rnd_q32(vosn_s3);
			p_s4     <= rnd_q32(pn_s3);
			t4_s4    <= T4_W'((tq_s3 + 54'd32768) >> 16);
		end
		// voltage error and full sensitivity
		if (adv[5]) begin
			e_s5   <= 35'(rv156_s4) - 35'(vos_s4);
			den_s5 <= $signed({1'b0, s0_q}) * 44'(p_s4);
			t4_s5  <= t4_s4;
		end
		// magnitudes; error prepared for division by 1000
		if (adv[6]) begin
			e_s6       <= e_s5;
			y_s6       <= 30'((em_c + 35'd500) >> 3);
			car_s6.ud  <= udm_c[UD_W-1:0];
			car_s6.sgn <= den_s5[43];
			car_s6.dz  <= (den_s5 == '0);
			car_s6.t4  <= t4_s5;
		end
		// error in nanovolts
		if (adv[7]) begin
			e_s7   <= e_s6;
			enm_s7 <= 23'((62'(y_s6) * 62'(RECIP_125)) >> 38);
			car_s7 <= car_s6;
		end
		if (adv[8]) begin
			e_s8   <= e_s7;
			sq_s8  <= 46'(enm_s7) * 46'(enm_s7);
			car_s8 <= car_s7;
		end
		// Seebeck term prepared for division by 1e7
		if (adv[9]) begin
			e_s9   <= e_s8;
			w_s9   <= 45'((54'(sq_s8) * 54'd134 + 54'd5000000) >> 7);
			car_s9 <= car_s8;
		end
		// reciprocal product in two halves
		if (adv[10]) begin
			e_s10   <= e_s9;
			pl_s10  <= 69'(w_s9[22:0]) * 69'(RECIP_78125);
			ph_s10  <= 68'(w_s9[44:23]) * 68'(RECIP_78125);
			car_s10 <= car_s9;
		end
		if (adv[11]) begin
			e_s11   <= e_s10;
			q2_s11  <= 29'(((91'(ph_s10) << 23) + 91'(pl_s10)) >> 62);
			car_s11 <= car_s10;
		end
		// fObj magnitude and quotient sign
		if (adv[12]) begin
			num_s12     <= 33'(f_c[35] ? -f_c : f_c);
			car_s12.ud  <= car_s11.ud;
			car_s12.sgn <= f_c[35] ^ car_s11.sgn;
			car_s12.dz  <= car_s11.dz;
			car_s12.t4  <= car_s11.t4;
		end
		// dividend scaled by 1e13 (shift by 13 is implied)
		if (adv[13]) begin
			prod_s13 <= 64'(num_s12) * 64'(FIVE_13);
			car_s13  <= car_s12;
		end
		// overflow test and first partial remainder
		if (adv[14]) begin
			rem_s14       <= UD_W'(prod_s13[63:30]);
			low_s14       <= {prod_s13[29:0], 13'b0};
			ud_s14        <= car_s13.ud;
			side_s14.t4   <= car_s13.t4;
			side_s14.neg  <= car_s13.sgn;
			side_s14.dz   <= car_s13.dz;
			side_s14.cap  <= {9'b0, prod_s13[63:30]} >= car_s13.ud;
		end
	end

	// fObj / S
	logic [Q_W-1:0]  quo_d;
	logic [UD_W-1:0] rem_d;
	logic [UD_W-1:0] ud_d;
	div_side_t       side_d;

	tpot_div u_div (
		.clk      (clk),
		.ld       (adv[57:15]),
		.ud_in    (ud_s14),
		.rem_in   (rem_s14),
		.low_in   (low_s14),
		.side_in  (side_s14),
		.quo      (quo_d),
		.rem      (rem_d),
		.ud_out   (ud_d),
		.side_out (side_d)
	);

	// quotient rounding, clipping, root argument
	logic [Q_W:0]        qr_s58;
	div_side_t           side_s58;
	logic [Q_W-1:0]      qm_c;
	logic signed [Q_W:0] qs_c;
	logic signed [Q_W:0] qs_s59;
	logic [T4_W-1:0]     t4_s59;
	logic                dz_s59;
	logic signed [44:0]  x_c;
	logic [43:0]         xin_s60;
	logic                bad_s60;

	always_comb begin
		qm_c = (side_s58.cap || qr_s58 > (45'd1 << 42)) ? (Q_W'(1) << 42) : qr_s58[Q_W-1:0];
		qs_c = side_s58.neg ? -$signed({1'b0, qm_c}) : $signed({1'b0, qm_c});
		x_c  = $signed({7'b0, t4_s59}) + 45'(qs_s59);
	end

	always_ff @(posedge clk) begin
		if (adv[58]) begin
			qr_s58   <= {1'b0, quo_d} + (Q_W+1)'({rem_d, 1'b0} >= {1'b0, ud_d});
			side_s58 <= side_d;
		end
		if (adv[59]) begin
			qs_s59 <= qs_c;
			t4_s59 <= side_s58.t4;
			dz_s59 <= side_s58.dz;
		end
		if (adv[60]) begin
			xin_s60 <= x_c[43:0];
			bad_s60 <= dz_s59 | x_c[44];
		end
	end

	// fourth root as two square roots
	logic [SQ_STEPS-1:0] root1;
	logic [SQ_STEPS-1:0] root2;
	logic                bad1;
	logic                bad2;

	tpot_isqrt u_sqrt_a (
		.clk     (clk),
		.ld      (adv[92:61]),
		.x_in    ({xin_s60, 20'b0}),
		.bad_in  (bad_s60),
		.root    (root1),
		.bad_out (bad1)
	);

	tpot_isqrt u_sqrt_b (
		.clk     (clk),
		.ld      (adv[124:93]),
		.x_in    ({2'b0, root1, 30'b0}),
		.bad_in  (bad1),
		.root    (root2),
		.bad_out (bad2)
	);

	// kelvin to celsius, rounding and clipping
	logic signed [32:0] diff_s125;
	logic               bad_s125;
	logic [32:0]        dmag_c;
	logic [12:0]        dq_c;
	logic signed [13:0] tmp_c;
	logic [10:0]        obj_s126;
	logic               ok_s126;

	always_comb begin
		dmag_c = diff_s125[32] ? 33'(-diff_s125) : 33'(diff_s125);
		dq_c   = 13'((dmag_c + 33'd524288) >> 20);
		tmp_c  = diff_s125[32] ? -$signed({1'b0, dq_c}) : $signed({1'b0, dq_c});
	end

	always_ff @(posedge clk) begin
		if (adv[125]) begin
			diff_s125 <= $signed({1'b0, root2}) - KELVIN_Q20;
			bad_s125  <= bad2;
		end
		if (adv[126]) begin
			if (bad_s125) begin
				obj_s126 <= '0;
				ok_s126  <= 1'b0;
			end else if (tmp_c > 14'sd1023) begin
				obj_s126 <= 11'sd1023;
				ok_s126  <= 1'b0;
			end else if (tmp_c < -14'sd512) begin
				obj_s126 <= -11'sd512;
				ok_s126  <= 1'b0;
			end else begin
				obj_s126 <= tmp_c[10:0];
				ok_s126  <= 1'b1;
			end
		end
	end

	assign m_tvalid = v_q[NS];
	assign m_tdata  = {5'b0, obj_s126};
	assign m_tuser  = ok_s126;

	// beats in flight change only by accepted input and output beats
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(v_q) ==
			$past($countones(v_q)) + int'($past(in_acc)) - int'($past(out_acc)))
		else $error("pipeline occupancy mismatch");

	// a rejected result carries one of the fixed fallback codes
	a_invalid_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
			(m_tdata[10:0] == 11'd0 || m_tdata[10:0] == 11'd1023 ||
			 m_tdata[10:0] == 11'h600))
		else $error("invalid result with unexpected code");

	// a good result never lies below absolute zero
	a_above_zero_k: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> $signed(m_tdata[10:0]) >= -11'sd274)
		else $error("valid result below absolute zero");

endmodule

// ===== rtl/tpot_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module tpot_div (
	input  logic                         clk,
	input  logic [tpot_pkg::Q_W-1:0]     ld,
	input  logic [tpot_pkg::UD_W-1:0]    ud_in,
	input  logic [tpot_pkg::UD_W-1:0]    rem_in,
	input  logic [tpot_pkg::Q_W-1:0]     low_in,
	input  tpot_pkg::div_side_t          side_in,
	output logic [tpot_pkg::Q_W-1:0]     quo,
	output logic [tpot_pkg::UD_W-1:0]    rem,
	output logic [tpot_pkg::UD_W-1:0]    ud_out,
	output tpot_pkg::div_side_t          side_out
);
	import tpot_pkg::*;

	logic [UD_W-1:0] rem_s  [Q_W];
	logic [UD_W-1:0] ud_s   [Q_W];
	logic [Q_W-1:0]  quo_s  [Q_W];
	logic [Q_W-1:0]  low_s  [Q_W];
	div_side_t       side_s [Q_W];

	generate
		for (genvar i = 0; i < Q_W; i++) begin : g_step
			logic [UD_W-1:0] rp;
			logic [UD_W-1:0] up;
			logic [Q_W-1:0]  qp;
			logic [Q_W-1:0]  lp;
			div_side_t       sp;
			logic [UD_W:0]   trial;
			logic            ge;

			// previous stage or pipeline entry
			if (i == 0) begin : g_first
				assign rp = rem_in;
				assign up = ud_in;
				assign qp = '0;
				assign lp = low_in;
				assign sp = side_in;
			end else begin : g_next
				assign rp = rem_s[i-1];
				assign up = ud_s[i-1];
				assign qp = quo_s[i-1];
				assign lp = low_s[i-1];
				assign sp = side_s[i-1];
			end

			// bring down the next dividend bit and try a subtract
			assign trial = {rp, lp[Q_W-1]};
			assign ge    = trial >= {1'b0, up};

			always_ff @(posedge clk) begin
				if (ld[i]) begin
					rem_s[i]  <= ge ? UD_W'(trial - {1'b0, up}) : trial[UD_W-1:0];
					quo_s[i]  <= {qp[Q_W-2:0], ge};
					low_s[i]  <= {lp[Q_W-2:0], 1'b0};
					ud_s[i]   <= up;
					side_s[i] <= sp;
				end
			end
		end
	endgenerate

	assign quo      = quo_s[Q_W-1];
	assign rem      = rem_s[Q_W-1];
	assign ud_out   = ud_s[Q_W-1];
	assign side_out = side_s[Q_W-1];

endmodule

// ===== rtl/tpot_isqrt.sv =====
// pipelined integer square root, one result bit per stage, floor result
module tpot_isqrt (
	input  logic                              clk,
	input  logic [tpot_pkg::SQ_STEPS-1:0]     ld,
	input  logic [tpot_pkg::SQ_W-1:0]         x_in,
	input  logic                              bad_in,
	output logic [tpot_pkg::SQ_STEPS-1:0]     root,
	output logic                              bad_out
);
	import tpot_pkg::*;

	logic [SQ_W-1:0] rem_s  [SQ_STEPS];
	logic [SQ_W-1:0] root_s [SQ_STEPS];
	logic            bad_s  [SQ_STEPS];

	generate
		for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
			localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);
			logic [SQ_W-1:0] xp;
			logic [SQ_W-1:0] rp;
			logic            bp;
			logic [SQ_W-1:0] trial;

			if (i == 0) begin : g_first
				assign xp = x_in;
				assign rp = '0;
				assign bp = bad_in;
			end else begin : g_next
				assign xp = rem_s[i-1];
				assign rp = root_s[i-1];
				assign bp = bad_s[i-1];
			end

			assign trial = rp + BIT;

			// accept the bit when the remainder covers the trial value
			always_ff @(posedge clk) begin
				if (ld[i]) begin
					if (xp >= trial) begin
						rem_s[i]  <= xp - trial;
						root_s[i] <= (rp >> 1) + BIT;
					end else begin
						rem_s[i]  <= xp;
						root_s[i] <= rp >> 1;
					end
					bad_s[i] <= bp;
				end
			end
		end
	endgenerate

	assign root    = root_s[SQ_STEPS-1][SQ_STEPS-1:0];
	assign bad_out = bad_s[SQ_STEPS-1];

endmodule

// ===== verif/thermopile_object_temperature_checker.sv =====
// checker for the thermopile object temperature block: predicts and compares result beats
module thermopile_object_temperature_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        m_tuser,
	output int          errors,
	output int          pending,
	output int          results_seen
);

	typedef struct packed {
		logic signed [10:0] obj_temp;
		logic               temp_ok;
	} obj_result_t;

	localparam longint TWO32  = 64'sd4294967296;
	localparam longint Q_CAP  = 64'sd1 << 42;
	localparam longint K_OFFS = 64'sd286418534;

	logic [11:0]  s0_reg;
	obj_result_t  expected_temps[$];

	// signed division, rounded to nearest with halves away from zero
	function automatic longint round_div(input longint n, input longint dv);
		if (n >= 0) return (n + dv / 2) / dv;
		return -((-n + dv / 2) / dv);
	endfunction

	// floor square root, bit by bit
	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// object temperature from one raw voltage and die temperature pair
	function automatic obj_result_t object_temp_of(input logic [15:0] rv_w,
			input logic [15:0] rt_w, input logic [11:0] s0);
		longint rv, rt, t, d, vos, e, en, f, p, den, t2, t4, x, q, temp;
		longint unsigned num, uq, ur, ud, s, r, fac;
		logic neg;
		obj_result_t o;
		rv = longint'(signed'(rv_w));
		rt = longint'(signed'(rt_w));
		t = rt * 512 + 64'sd17901158;
		d = rt * 512 - 64'sd1638400;
		o.obj_temp = '0;
		o.temp_ok = 1'b0;
		// offset polynomial and Seebeck correction
		vos = round_div(-64'sd29400000 * TWO32 - 64'sd570000 * 64'sd65536 * d
			+ 64'sd4630 * d * d, TWO32);
		e = rv * 64'sd156250 - vos;
		en = round_div(e, 1000);
		f = e + round_div(64'sd134 * en * en, 64'sd10000000);
		// sensitivity polynomial
		p = round_div(64'sd1000000000 * TWO32 + 64'sd1750000 * 64'sd65536 * d
			- 64'sd16780 * d * d, TWO32);
		den = longint'({52'd0, s0}) * p;
		if (den == 0) return o;
		neg = (f < 0) != (den < 0);
		num = (f < 0) ? -f : f;
		ud = (den < 0) ? -den : den;
		// long division scaled by 1e13, capped
		uq = num / ud;
		ur = num % ud;
		for (int i = 0; i < 3; i++) begin
			fac = (i == 2) ? 64'd1000 : 64'd100000;
			if (uq > Q_CAP) begin
				uq = Q_CAP;
				ur = 0;
			end
			uq = uq * fac + (ur * fac) / ud;
			ur = (ur * fac) % ud;
		end
		if (2 * ur >= ud) uq++;
		if (uq > Q_CAP) uq = Q_CAP;
		q = neg ? -longint'(uq) : longint'(uq);
		// die temperature to the fourth power plus correction
		t2 = round_div(t * t, 64'sd1 << 24);
		t4 = round_div(t2 * t2, 65536);
		x = t4 + q;
		if (x < 0) return o;
		s = floor_sqrt(longint'(x) << 20);
		r = floor_sqrt(s << 30);
		temp = round_div(longint'(r) - K_OFFS, 64'sd1 << 20);
		o.temp_ok = 1'b1;
		if (temp > 1023) begin
			temp = 1023;
			o.temp_ok = 1'b0;
		end else if (temp < -512) begin
			temp = -512;
			o.temp_ok = 1'b0;
		end
		o.obj_temp = temp[10:0];
		return o;
	endfunction

	// register shadow, predict on input beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin
		obj_result_t want;
		if (!arst_n) begin
			s0_reg <= 12'd640;
			errors <= 0;
			pending <= 0;
			results_seen <= 0;
			expected_temps.delete();
		end else begin
			if (cfg_we) s0_reg <= cfg_wdata;
			if (s_tvalid && s_tready)
				expected_temps.push_back(object_temp_of(s_tdata[15:0], s_tdata[31:16], s0_reg));
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_temps.size() == 0) begin
					$display("%0t: result beat with nothing expected: temp %0d ok %0b",
						$time, $signed(m_tdata[10:0]), m_tuser);
					errors <= errors + 1;
				end else begin
					want = expected_temps.pop_front();
					if (m_tdata[10:0] !== want.obj_temp || m_tdata[15:11] !== 5'd0) begin
						$display("%0t: object_temp expected %0d, got %0d (tdata %h)",
							$time, want.obj_temp, $signed(m_tdata[10:0]), m_tdata);
						errors <= errors + 1;
					end else if (m_tuser !== want.temp_ok) begin
						$display("%0t: result_valid expected %0b, got %0b",
							$time, want.temp_ok, m_tuser);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_temps.size();
		end
	end

endmodule

// ===== verif/thermopile_object_temperature_tb.sv =====
// testbench top: stimulus, idling phases and verdict for the thermopile block
module thermopile_object_temperature_tb;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [11:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	int          errors, pending, results_seen;
	int          src_idle_pct, sink_stall_pct;
	int          quiet_cycles;
	int          beats_sent;

	thermopile_object_temperature u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	thermopile_object_temperature_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver stalls at random
	always @(negedge clk) m_tready <= ($urandom_range(99) >= sink_stall_pct);

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("thermopile_object_temperature_tb: done, errors");
			$finish;
		end
	end

	// one input beat, with random sender gaps; called at a falling edge
	task automatic send_pair(input logic [15:0] volt, input logic [15:0] temp);
		s_tvalid = 1'b0;
		while ($urandom_range(99) < src_idle_pct) @(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {temp, volt};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid = 1'b0;
		beats_sent++;
	endtask

	task automatic write_s0(input logic [11:0] val);
		while (pending != 0 || m_tvalid) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// mostly plausible die temperatures, sometimes the whole word
	task automatic random_pairs(input int n);
		logic [15:0] v, t;
		for (int i = 0; i < n; i++) begin
			v = $urandom;
			if ($urandom_range(3) == 0) t = $urandom;
			else t = 16'($signed($urandom_range(21120)) - 16'sd5120);
			if ($urandom_range(3) == 0) v = 16'($signed($urandom_range(400)) - 16'sd200);
			send_pair(v, t);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		quiet_cycles = 0;
		beats_sent = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners at the reset sensitivity
		send_pair(16'h0000, 16'h0000);
		send_pair(16'h7fff, 16'h7fff);
		send_pair(16'h8000, 16'h8000);
		send_pair(16'h7fff, 16'h8000);
		send_pair(16'h8000, 16'h7fff);
		send_pair(16'hffff, 16'h0c80);
		send_pair(16'h0001, 16'h0c80);
		send_pair(16'h0000, 16'h3200);
		send_pair(16'h0100, 16'hec00);
		send_pair(16'hff00, 16'h1900);
		// weakest sensitivity: negative root argument and top clipping
		write_s0(12'd1);
		send_pair(16'h8000, 16'h0000);
		send_pair(16'hc000, 16'h0c80);
		send_pair(16'h7fff, 16'h0c80);
		send_pair(16'h4000, 16'h8000);
		send_pair(16'h8000, 16'h7fff);
		// strongest sensitivity
		write_s0(12'd4095);
		send_pair(16'h7fff, 16'h0c80);
		send_pair(16'h8000, 16'h0c80);
		send_pair(16'h0000, 16'h8000);
		send_pair(16'h5555, 16'haaaa);
		send_pair(16'haaaa, 16'h5555);

		// random phases over the idling modes and several sensitivities
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
				default: begin src_idle_pct = 37; sink_stall_pct = 37; end
			endcase
			write_s0(ph == 0 ? 12'd640 : ph == 1 ? 12'd1 : 12'($urandom_range(4095, 1)));
			random_pairs(50);
			write_s0(ph == 2 ? 12'd4095 : 12'($urandom_range(1200, 1)));
			random_pairs(50);
		end

		sink_stall_pct = 0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("run covered %0d input beats and %0d result beats", beats_sent, results_seen);
		$display("over four idling modes and sensitivities from 1 to 4095");
		if (errors == 0 && pending == 0) begin
			$display("thermopile_object_temperature_tb: done, clean");
		end else begin
			$display("thermopile_object_temperature_tb: done, errors");
		end
		$finish;
	end

endmodule
